@@ sv/sha_pkg.sv @@
// SHA-256 digest package: round constants, initial hash values, shared types.
// No dependencies.
package sha_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } sha_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } sha_state_t;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [255:0] START_HASH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        case (t)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

@@ sv/sha256_message_digest.sv @@
// SHA-256 message digest top level: input queue feeding the compression core.
// Depends on sha_pkg, sha_queue, sha_core.
//
// Usage: stream message bytes on the s_axis channel, one beat per byte with
// has_byte set; end_of_message on a beat closes the message (with or without
// a byte). The digest leaves on m_axis as four beats of 64 bits, part 0 first
// (hash words 0 and 1), tlast on part 3.
// A byte that does not complete a 64-byte block is absorbed while the core stays idle.
// A block-completing byte starts a compression: load, 64 rounds in the single
// round unit, then fold. An end beat compresses one block when the length fits
// the tail block, else two (also when its byte completes a block), then sends
// the four output beats.
// A two-entry queue decouples the input from the core.
// Reset clears the queue, loads the initial hash and zeroes the byte count.
// When the receiver stalls, the core holds the current part and stops
// consuming; the queue then fills and s_axis_tready drops.
module sha256_message_digest (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // data_byte[7:0], has_byte[8], zero fill
    input  logic        s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // digest_part[63:0], part_index[65:64], zero fill
    output logic        m_axis_tlast    // last_part
);
    import sha_pkg::*;

    sha_item_t item_in, item_q;
    logic      q_valid, q_ready;
    logic [71:0] core_data;

    assign item_in.data_byte      = s_axis_tdata[7:0];
    assign item_in.has_byte       = s_axis_tdata[8];
    assign item_in.end_of_message = s_axis_tlast;

    sha_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item(item_in),
        .out_valid(q_valid), .out_ready(q_ready), .out_item(item_q)
    );

    sha_core u_core (
        .clk(clk), .rst_n(rst_n),
        .in_valid(q_valid), .in_ready(q_ready), .in_item(item_q),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_data(core_data), .out_last(m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, core_data[65:0]};
endmodule

@@ sv/sha_queue.sv @@
// Two-entry queue of input beats between the front and the back end.
// Depends on sha_pkg.
module sha_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sha_pkg::sha_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output sha_pkg::sha_item_t out_item
);
    import sha_pkg::*;

    sha_item_t  mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_item  = mem_reg[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

@@ sv/sha_core.sv @@
// Back end: block buffer, padding, 64-round compression and digest output.
// Depends on sha_pkg.
module sha_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sha_pkg::sha_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [71:0]        out_data,
    output logic               out_last
);
    import sha_pkg::*;

    sha_state_t  state_reg, state_next;
    logic [31:0] blk_reg [16];
    logic [31:0] w_reg [16];
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [60:0] cnt_reg;
    logic [5:0]  t_reg;
    logic [1:0]  part_reg;
    // pad_reg: message end taken, digest output pending; len_reg: tail block with length pending
    logic        pad_reg, len_reg;

    logic [5:0]  pos;
    logic [3:0]  wi;
    logic [1:0]  lane;
    logic        take;
    logic        full_eom;
    logic [60:0] cnt_inc;
    logic [5:0]  rest;
    logic [63:0] bits;
    logic [31:0] w15, w2, s0, s1, wn, wt, t1, t2, e, a;

    assign pos  = cnt_reg[5:0];
    assign wi   = pos[5:2];
    assign lane = pos[1:0];
    assign take = in_valid && (state_reg == ST_IDLE);

    // byte completes a block on the end beat: tail goes into a second block
    assign full_eom = in_item.has_byte && (pos == 6'd63) && in_item.end_of_message;
    assign cnt_inc  = in_item.has_byte ? cnt_reg + 61'd1 : cnt_reg;
    assign rest     = cnt_inc[5:0];
    assign bits     = {cnt_inc, 3'd0};

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign out_last  = (part_reg == 2'd3);
    assign out_data  = {5'd0, out_last, part_reg,
                        h_reg[{part_reg, 1'b0}], h_reg[{part_reg, 1'b1}]};

    assign w15 = w_reg[1];
    assign w2  = w_reg[14];
    assign s0  = {w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3);
    assign s1  = {w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10);
    assign wn  = w_reg[0] + s0 + w_reg[9] + s1;
    assign wt  = w_reg[0];
    assign e   = v_reg[4];
    assign a   = v_reg[0];
    assign t1  = v_reg[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
                 + ((e & v_reg[5]) ^ (~e & v_reg[6])) + round_k(t_reg) + wt;
    assign t2  = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
                 + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take && ((in_item.has_byte && pos == 6'd63) || in_item.end_of_message))
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (t_reg == 6'd63)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                if (len_reg)
                begin
                    state_next = ST_ROUND;
                end
                else if (pad_reg)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (out_ready && part_reg == 2'd3)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath. Padding of the current block happens in one pass over words.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    // b: buffer with the new byte and, on an end beat that does not complete a block, the padding
                    logic [31:0] b [16];
                    b = blk_reg;
                    if (in_item.has_byte)
                    begin
                        if (lane == 2'd0)
                        begin
                            b[wi] = 32'd0;
                        end
                        b[wi][(5'd24 - {lane, 3'd0}) +: 8] = in_item.data_byte;
                    end
                    if (in_item.end_of_message && !full_eom)
                    begin
                        for (int i = 0; i < 16; i++)
                        begin
                            if (i[3:0] > rest[5:2])
                            begin
                                b[i] = 32'd0;
                            end
                        end
                        if (rest[1:0] == 2'd0)
                        begin
                            b[rest[5:2]] = 32'd0;
                        end
                        b[rest[5:2]][(5'd24 - {rest[1:0], 3'd0}) +: 8] = PAD_BYTE;
                        if (rest < 6'd56)
                        begin
                            b[14] = bits[63:32];
                            b[15] = bits[31:0];
                        end
                    end
                    blk_reg <= b;
                    w_reg   <= b;
                    v_reg   <= h_reg;
                    t_reg   <= 6'd0;
                end
            end
            ST_ROUND:
            begin
                for (int i = 0; i < 15; i++)
                begin
                    w_reg[i] <= w_reg[i + 1];
                end
                w_reg[15] <= wn;
                v_reg[7] <= v_reg[6];
                v_reg[6] <= v_reg[5];
                v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2];
                v_reg[2] <= v_reg[1];
                v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + t2;
                t_reg <= t_reg + 6'd1;
            end
            ST_FOLD:
            begin
                if (len_reg)
                begin
                    logic [31:0] b [16];
                    for (int i = 0; i < 16; i++)
                    begin
                        b[i] = 32'd0;
                    end
                    // pad byte still owed when the data ended on a block boundary
                    if (cnt_reg[5:0] == 6'd0)
                    begin
                        b[0] = {PAD_BYTE, 24'd0};
                    end
                    b[14] = cnt_reg[60:29];
                    b[15] = {cnt_reg[28:0], 3'd0};
                    blk_reg <= b;
                    w_reg   <= b;
                    for (int i = 0; i < 8; i++)
                    begin
                        v_reg[i] <= h_reg[i] + v_reg[i];
                    end
                    t_reg <= 6'd0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= START_HASH[(7 - i) * 32 +: 32];
            end
            pad_reg  <= 1'b0;
            len_reg  <= 1'b0;
            cnt_reg  <= '0;
            part_reg <= 2'd0;
        end
        else
        begin
            if (take)
            begin
                pad_reg <= in_item.end_of_message;
                len_reg <= in_item.end_of_message && (full_eom || rest >= 6'd56);
                cnt_reg <= cnt_inc;
            end
            if (state_reg == ST_FOLD)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= h_reg[i] + v_reg[i];
                end
                len_reg <= 1'b0;
            end
            if (state_reg == ST_OUT && out_ready)
            begin
                part_reg <= part_reg + 2'd1;
                if (part_reg == 2'd3)
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= START_HASH[(7 - i) * 32 +: 32];
                    end
                    pad_reg <= 1'b0;
                    cnt_reg <= '0;
                end
            end
        end
    end
endmodule

@@ tb/sha256_message_digest_tb.sv @@
// Testbench for sha256_message_digest: streams byte messages, predicts SHA-256 digests.
// Depends on sha_pkg and the sha256_message_digest RTL.
`timescale 1ns / 1ps

module sha256_message_digest_tb;
    import sha_pkg::*;

    localparam int SENDER_FIRST = 0;
    localparam int RECEIVER_FIRST = 1;
    localparam int NO_IDLE = 2;

    localparam logic [31:0] ROUND_CONST [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    typedef struct packed {
        logic [63:0] digest_part;
        logic [1:0]  part_index;
        logic        last_part;
    } digest_beat_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tlast;

    sha_item_t    pending_items[$];
    digest_beat_t expected_parts[$];
    int           error_count;
    int           idle_mode;

    logic [31:0] chain_hash[8];
    logic [31:0] msg_block[16];
    logic [60:0] bytes_taken;

    sha256_message_digest u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_block();
        logic [31:0] w[16];
        logic [31:0] v[8];
        logic [31:0] wt, s0, s1, t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = msg_block[i];
        for (int i = 0; i < 8; i++)
            v[i] = chain_hash[i];
        for (int t = 0; t < 64; t++)
        begin
            if (t < 16)
                wt = w[t];
            else
            begin
                s0 = rotr(w[(t-15)&15], 7) ^ rotr(w[(t-15)&15], 18) ^ (w[(t-15)&15] >> 3);
                s1 = rotr(w[(t-2)&15], 17) ^ rotr(w[(t-2)&15], 19) ^ (w[(t-2)&15] >> 10);
                wt = w[t&15] + s0 + w[(t-7)&15] + s1;
                w[t&15] = wt;
            end
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[t] + wt;
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain_hash[i] += v[i];
    endtask

    task automatic place_byte(input int pos, input logic [7:0] b);
        if ((pos & 3) == 0)
            msg_block[pos >> 2] = '0;
        msg_block[pos >> 2] |= 32'(b) << (24 - 8 * (pos & 3));
    endtask

    task automatic hash_item(input sha_item_t it);
        int          pos;
        logic [63:0] bit_len;
        digest_beat_t d;
        if (it.has_byte)
        begin
            pos = int'(bytes_taken[5:0]);
            place_byte(pos, it.data_byte);
            bytes_taken = bytes_taken + 61'd1;
            if (pos == 63)
                compress_block();
        end
        if (it.end_of_message)
        begin
            pos = int'(bytes_taken[5:0]);
            bit_len = {bytes_taken, 3'b000};
            place_byte(pos, PAD_BYTE);
            for (int p = pos + 1; p < 64; p++)
                place_byte(p, 8'h00);
            if (pos + 9 > 64)
            begin
                compress_block();
                for (int i = 0; i < 16; i++)
                    msg_block[i] = '0;
            end
            msg_block[14] = bit_len[63:32];
            msg_block[15] = bit_len[31:0];
            compress_block();
            for (int k = 0; k < 4; k++)
            begin
                d.digest_part = {chain_hash[2*k], chain_hash[2*k+1]};
                d.part_index = 2'(k);
                d.last_part = (k == 3);
                expected_parts = {expected_parts, d};
            end
            for (int i = 0; i < 8; i++)
                chain_hash[i] = START_HASH[255 - 32*i -: 32];
            bytes_taken = '0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        error_count++;
    endtask

    function automatic sha_item_t mk_item(input logic [7:0] b, input bit hb, input bit eom);
        sha_item_t it;
        it.data_byte = b;
        it.has_byte = hb;
        it.end_of_message = eom;
        return it;
    endfunction

    task automatic add_item(input sha_item_t it);
        pending_items = {pending_items, it};
    endtask

    task automatic push_message(input int len, input bit eom_on_last);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                add_item(mk_item(8'($urandom), 1'b0, 1'b0));
            add_item(mk_item(8'($urandom), 1'b1, eom_on_last && i == len - 1));
        end
        if (!eom_on_last || len == 0)
            add_item(mk_item(8'($urandom), 1'b0, 1'b1));
    endtask

    // driver: pops the next beat on handshake, consumes into the predictor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tlast <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                hash_item(pending_items.pop_front());
            if (s_axis_tvalid && !s_axis_tready)
                s_axis_tvalid <= 1'b1;
            else if (pending_items.size() > 0 && (idle_mode == RECEIVER_FIRST
                    ? $urandom_range(0, 99) >= 77
                    : idle_mode == SENDER_FIRST ? $urandom_range(0, 99) >= 21 : 1'b1))
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {7'b0, pending_items[0].has_byte, pending_items[0].data_byte};
                s_axis_tlast <= pending_items[0].end_of_message;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        digest_beat_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_parts.size() == 0)
                    report_mismatch("unexpected beat", m_axis_tdata[63:0], '0);
                else
                begin
                    want = expected_parts.pop_front();
                    if (m_axis_tdata[63:0] !== want.digest_part)
                        report_mismatch("digest_part", m_axis_tdata[63:0], want.digest_part);
                    if (m_axis_tdata[65:64] !== want.part_index)
                        report_mismatch("part_index", 64'(m_axis_tdata[65:64]),
                                        64'(want.part_index));
                    if (m_axis_tlast !== want.last_part)
                        report_mismatch("last_part", 64'(m_axis_tlast), 64'(want.last_part));
                end
            end
            m_axis_tready <= idle_mode == SENDER_FIRST ? $urandom_range(0, 99) >= 77
                           : idle_mode == RECEIVER_FIRST ? $urandom_range(0, 99) >= 21 : 1'b1;
        end
    end

    initial
    begin
        #3000000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        error_count = 0;
        idle_mode = SENDER_FIRST;
        for (int i = 0; i < 8; i++)
            chain_hash[i] = START_HASH[255 - 32*i -: 32];
        for (int i = 0; i < 16; i++)
            msg_block[i] = '0;
        bytes_taken = '0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty message, "abc", idle beats, extremes, tail boundary lengths
        add_item(mk_item(8'h00, 1'b0, 1'b0));
        add_item(mk_item(8'hff, 1'b0, 1'b1));
        add_item(mk_item(8'h61, 1'b1, 1'b0));
        add_item(mk_item(8'h62, 1'b1, 1'b0));
        add_item(mk_item(8'hff, 1'b0, 1'b0));
        add_item(mk_item(8'h63, 1'b1, 1'b1));
        add_item(mk_item(8'hff, 1'b1, 1'b1));
        add_item(mk_item(8'h00, 1'b1, 1'b0));
        add_item(mk_item(8'h00, 1'b0, 1'b1));
        push_message(55, 1);
        push_message(56, 0);
        push_message(64, 1);

        for (int ph = 0; ph < 3; ph++)
        begin
            if (ph == 1)
                push_message($urandom_range(0, 70), 1'($urandom_range(0, 1)));
            else
                for (int i = 0; i < 3; i++)
                    push_message($urandom_range(0, 12), 1'($urandom_range(0, 1)));
            wait (pending_items.size() == 0 && expected_parts.size() == 0);
            repeat (300) @(posedge clk);
            if (ph < 2)
                idle_mode = ph + 1;
        end

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

@@ filelist.f @@
sv/sha_pkg.sv
sv/sha_queue.sv
sv/sha_core.sv
sv/sha256_message_digest.sv
tb/sha256_message_digest_tb.sv
